@@ hdl/rv32x_pkg.sv @@
// Package for the RV32I execute core: opcodes, result kinds, trap causes, decode helpers.
// No dependencies.
package rv32x_pkg;

    localparam int unsigned RegCount = 32;
    localparam int unsigned RegIdxW  = 5;

    typedef enum logic [1:0] {
        K_RETIRED = 2'd0,
        K_TRAP    = 2'd1,
        K_LOAD    = 2'd2,
        K_STORE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        C_ILLEGAL  = 2'd0,
        C_BREAK    = 2'd1,
        C_NOTIMPL  = 2'd2,
        C_MEMFAULT = 2'd3
    } t_cause;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_PCREL  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STR    = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;
    localparam logic [6:0] OPC_SYS    = 7'h73;

    localparam logic [6:0]  F7_ALT    = 7'b0100000;
    localparam logic [11:0] F12_ECALL = 12'h000;
    localparam logic [11:0] F12_EBRK  = 12'h001;
    localparam logic [11:0] F12_URET  = 12'h002;
    localparam logic [11:0] F12_SRET  = 12'h102;
    localparam logic [11:0] F12_MRET  = 12'h302;

    // Architectural side effects of one item, from execute stage to state.
    typedef struct packed {
        logic                 rf_we;
        logic [RegIdxW-1:0]   rf_idx;
        logic [31:0]          rf_data;
        logic [31:0]          pc;
        logic                 trap;
        logic                 ld_set;
        logic                 ld_clr;
        logic [2:0]           ld_fmt;
        logic [RegIdxW-1:0]   ld_dst;
        logic [31:0]          ld_addr;
    } t_upd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] next_pc;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic [31:0] store_data;
        logic [1:0]  trap_cause;
        logic [31:0] trap_value;
    } t_res;

    function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

@@ hdl/rv32x_regfile.sv @@
// Register file, x0 at zero: two combinational read ports, item and sp write ports.
// Depends on rv32x_pkg.
module rv32x_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rv32x_pkg::RegIdxW-1:0] i_ra,
    input  logic [rv32x_pkg::RegIdxW-1:0] i_rb,
    output logic [31:0]                   o_a,
    output logic [31:0]                   o_b,
    input  logic                          i_we,
    input  logic [rv32x_pkg::RegIdxW-1:0] i_widx,
    input  logic [31:0]                   i_wdata,
    input  logic                          i_sp_we,
    input  logic [31:0]                   i_sp
);
    import rv32x_pkg::*;

    logic [31:0] r_regs [1:RegCount-1];
    logic        ra_ok, rb_ok, w_ok;

    // indexes past the implemented registers read as zero and drop writes
    assign ra_ok = (i_ra != '0) && (32'(i_ra) < RegCount);
    assign rb_ok = (i_rb != '0) && (32'(i_rb) < RegCount);
    assign w_ok  = (i_widx != '0) && (32'(i_widx) < RegCount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i < RegCount; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_we && w_ok) begin
                r_regs[i_widx] <= i_wdata;
            end
            // config write to sp lands after any item write
            if (i_sp_we) begin
                r_regs[2] <= i_sp;
            end
        end
    end

    assign o_a = ra_ok ? r_regs[i_ra] : '0;
    assign o_b = rb_ok ? r_regs[i_rb] : '0;

endmodule

@@ hdl/rv32x_exec.sv @@
// Combinational decode and execute of one item against current architectural state.
// Depends on rv32x_pkg.
module rv32x_exec (
    input  logic                          i_mode,
    input  logic [31:0]                   i_instruction,
    input  logic [31:0]                   i_load_data,
    input  logic                          i_load_fault,
    input  logic [31:0]                   i_a,
    input  logic [31:0]                   i_b,
    input  logic [31:0]                   i_pc,
    input  logic [31:0]                   i_saved_pc,
    input  logic                          i_ld_pend,
    input  logic [2:0]                    i_ld_fmt,
    input  logic [rv32x_pkg::RegIdxW-1:0] i_ld_dst,
    input  logic [31:0]                   i_ld_addr,
    output rv32x_pkg::t_upd               o_upd,
    output rv32x_pkg::t_res               o_res
);
    import rv32x_pkg::*;

    logic [31:0] w, imm_i, imm_s, imm_b, imm_j, r, ld_v, pc4;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  sh;
    logic        take, ill;

    always_comb begin
        w     = i_instruction;
        op    = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        sh    = w[24:20];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        pc4   = i_pc + 32'd4;
        r     = '0;
        take  = 1'b0;
        ill   = 1'b0;
        ld_v  = '0;

        o_upd = '0;
        o_upd.pc      = i_pc;
        o_upd.rf_idx  = w[11:7];
        o_upd.ld_fmt  = f3;
        o_upd.ld_dst  = w[11:7];
        o_upd.ld_addr = i_a + imm_i;
        o_res = '0;
        o_res.kind = K_RETIRED;

        if (i_mode) begin
            if (i_ld_pend) begin
                o_upd.ld_clr = 1'b1;
                if (i_load_fault) begin
                    o_upd.trap       = 1'b1;
                    o_res.kind       = K_TRAP;
                    o_res.trap_cause = C_MEMFAULT;
                    o_res.trap_value = i_ld_addr;
                end else begin
                    unique case (i_ld_fmt)
                        3'd0:    ld_v = {{24{i_load_data[7]}}, i_load_data[7:0]};
                        3'd1:    ld_v = {{16{i_load_data[15]}}, i_load_data[15:0]};
                        3'd4:    ld_v = {24'd0, i_load_data[7:0]};
                        3'd5:    ld_v = {16'd0, i_load_data[15:0]};
                        default: ld_v = i_load_data;
                    endcase
                    o_upd.rf_we   = 1'b1;
                    o_upd.rf_idx  = i_ld_dst;
                    o_upd.rf_data = ld_v;
                    o_upd.pc      = pc4;
                end
            end
        end else begin
            o_upd.ld_clr = 1'b1;
            unique case (op)
                OPC_LUI: begin
                    o_upd.rf_we = 1'b1; o_upd.rf_data = {w[31:12], 12'd0}; o_upd.pc = pc4;
                end
                OPC_PCREL: begin
                    o_upd.rf_we = 1'b1; o_upd.rf_data = i_pc + {w[31:12], 12'd0};
                    o_upd.pc = pc4;
                end
                OPC_JAL: begin
                    o_upd.rf_we = 1'b1; o_upd.rf_data = pc4; o_upd.pc = i_pc + imm_j;
                end
                OPC_JALR: begin
                    if (f3 != 3'd0) ill = 1'b1;
                    else begin
                        o_upd.rf_we = 1'b1; o_upd.rf_data = pc4;
                        o_upd.pc = (i_a + imm_i) & ~32'd1;
                    end
                end
                OPC_BRCH: begin
                    unique case (f3)
                        3'd0: take = i_a == i_b;
                        3'd1: take = i_a != i_b;
                        3'd4: take = lt_s(i_a, i_b);
                        3'd5: take = !lt_s(i_a, i_b);
                        3'd6: take = i_a < i_b;
                        3'd7: take = i_a >= i_b;
                        default: ill = 1'b1;
                    endcase
                    o_upd.pc = i_pc + (take ? imm_b : 32'd4);
                end
                OPC_LOAD: begin
                    if (f3 == 3'd3 || f3 > 3'd5) ill = 1'b1;
                    else begin
                        o_upd.ld_set      = 1'b1;
                        o_res.kind        = K_LOAD;
                        o_res.mem_address = i_a + imm_i;
                        o_res.mem_size    = f3[1:0];
                    end
                end
                OPC_STR: begin
                    if (f3 > 3'd2) ill = 1'b1;
                    else begin
                        o_res.kind        = K_STORE;
                        o_res.mem_address = i_a + imm_s;
                        o_res.mem_size    = f3[1:0];
                        o_res.store_data  = (f3 == 3'd0) ? {24'd0, i_b[7:0]} :
                                            (f3 == 3'd1) ? {16'd0, i_b[15:0]} : i_b;
                        o_upd.pc = pc4;
                    end
                end
                OPC_IMM: begin
                    unique case (f3)
                        3'd0: r = i_a + imm_i;
                        3'd2: r = {31'd0, lt_s(i_a, imm_i)};
                        3'd3: r = {31'd0, i_a < imm_i};
                        3'd4: r = i_a ^ imm_i;
                        3'd6: r = i_a | imm_i;
                        3'd7: r = i_a & imm_i;
                        3'd1: begin
                            if (f7 != 7'd0) ill = 1'b1;
                            r = i_a << sh;
                        end
                        default: begin
                            if (f7 == 7'd0) r = i_a >> sh;
                            else if (f7 == F7_ALT) r = $unsigned($signed(i_a) >>> sh);
                            else ill = 1'b1;
                        end
                    endcase
                    o_upd.rf_we = !ill; o_upd.rf_data = r; o_upd.pc = pc4;
                end
                OPC_REG: begin
                    if (f7 == F7_ALT && f3 == 3'd0) r = i_a - i_b;
                    else if (f7 == F7_ALT && f3 == 3'd5)
                        r = $unsigned($signed(i_a) >>> i_b[4:0]);
                    else if (f7 != 7'd0) ill = 1'b1;
                    else begin
                        unique case (f3)
                            3'd0: r = i_a + i_b;
                            3'd1: r = i_a << i_b[4:0];
                            3'd2: r = {31'd0, lt_s(i_a, i_b)};
                            3'd3: r = {31'd0, i_a < i_b};
                            3'd4: r = i_a ^ i_b;
                            3'd5: r = i_a >> i_b[4:0];
                            3'd6: r = i_a | i_b;
                            default: r = i_a & i_b;
                        endcase
                    end
                    o_upd.rf_we = !ill; o_upd.rf_data = r; o_upd.pc = pc4;
                end
                OPC_FENCE: begin
                    if (f3 == 3'd0) begin
                        o_upd.trap = 1'b1; o_res.kind = K_TRAP; o_res.trap_cause = C_NOTIMPL;
                    end else ill = 1'b1;
                end
                OPC_SYS: begin
                    if (w[19:7] != 13'd0) ill = 1'b1;
                    else if (w[31:20] == F12_ECALL || w[31:20] == F12_URET ||
                             w[31:20] == F12_SRET) begin
                        o_upd.trap = 1'b1; o_res.kind = K_TRAP; o_res.trap_cause = C_NOTIMPL;
                    end else if (w[31:20] == F12_EBRK) begin
                        o_upd.trap = 1'b1; o_res.kind = K_TRAP; o_res.trap_cause = C_BREAK;
                    end else if (w[31:20] == F12_MRET) begin
                        o_upd.pc = i_saved_pc + 32'd4;
                    end else ill = 1'b1;
                end
                default: ill = 1'b1;
            endcase
            if (ill) begin
                o_upd.rf_we      = 1'b0;
                o_upd.ld_set     = 1'b0;
                o_upd.trap       = 1'b1;
                o_upd.pc         = i_pc;
                o_res            = '0;
                o_res.kind       = K_TRAP;
                o_res.trap_cause = C_ILLEGAL;
                o_res.trap_value = w;
            end
        end
        if (o_upd.trap) o_upd.pc = i_pc;
        o_res.next_pc = o_upd.pc;
    end

endmodule

@@ hdl/rv32i_execute_core.sv @@
// Top level of the RV32I execute core: input register, state, result register, APB port.
// Depends on rv32x_pkg, rv32x_regfile and rv32x_exec.
//
// Use: each input item is either an instruction word (mode 0) or the response to a
// load that an earlier item requested (mode 1). Every item gives exactly one result
// item: retired, trap taken, load request or store request, with the new PC.
// Channels use valid/stall; an item moves when valid is high and stall is low.
// Path: an accepted item is held in the input register, where it is decoded and
// executed against the register file, PC and trap registers; its result is loaded
// into the output register when the item advances, which raises o_valid.
// Throughput: one item per cycle while the receiver does not stall; the execute path
// runs combinationally from the input register through the register file read, ALU
// and write-back. State is committed when the item leaves the input register, so
// the next item always sees it.
// If the receiver stalls, the output register holds its result, the input register
// holds its item, and the input side is stalled only while both are full and the
// receiver is stalling.
// Reset (synchronous, active low) clears the registers, PC, trap state and pending
// load and sets the stack pointer register to zero. Writing initial_stack_pointer
// over APB (address 0) also loads x2 at once. Reads return it at address 0, else zero.
module rv32i_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_load_data,
    input  logic        i_load_fault,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_next_pc,
    output logic [31:0] o_mem_address,
    output logic [1:0]  o_mem_size,
    output logic [31:0] o_store_data,
    output logic [1:0]  o_trap_cause,
    output logic [31:0] o_trap_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rv32x_pkg::*;

    // input register
    logic        r_iv;
    logic        r_mode, r_fault;
    logic [31:0] r_instr, r_ldata;
    // architectural state
    logic [31:0] r_pc, r_saved_pc, r_saved_value, r_ld_addr, r_isp;
    logic [1:0]  r_saved_cause;
    logic        r_ld_pend;
    logic [2:0]  r_ld_fmt;
    logic [RegIdxW-1:0] r_ld_dst;
    // output register
    logic        r_ov;
    t_res        r_res;

    logic        adv, out_free, sp_we;
    logic [31:0] a, b;
    t_upd        upd;
    t_res        res;

    assign out_free = !r_ov || !i_stall;
    assign adv      = r_iv && out_free;
    assign o_stall  = r_iv && !out_free;
    assign sp_we    = psel && penable && pwrite && paddr == 3'd0;
    assign pready   = 1'b1;
    assign prdata   = (paddr == 3'd0) ? r_isp : 32'd0;

    rv32x_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ra    (r_instr[19:15]),
        .i_rb    (r_instr[24:20]),
        .o_a     (a),
        .o_b     (b),
        .i_we    (adv && upd.rf_we),
        .i_widx  (upd.rf_idx),
        .i_wdata (upd.rf_data),
        .i_sp_we (sp_we),
        .i_sp    (pwdata)
    );

    rv32x_exec u_ex (
        .i_mode        (r_mode),
        .i_instruction (r_instr),
        .i_load_data   (r_ldata),
        .i_load_fault  (r_fault),
        .i_a           (a),
        .i_b           (b),
        .i_pc          (r_pc),
        .i_saved_pc    (r_saved_pc),
        .i_ld_pend     (r_ld_pend),
        .i_ld_fmt      (r_ld_fmt),
        .i_ld_dst      (r_ld_dst),
        .i_ld_addr     (r_ld_addr),
        .o_upd         (upd),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv          <= 1'b0;
            r_ov          <= 1'b0;
            r_pc          <= '0;
            r_saved_pc    <= '0;
            r_saved_cause <= '0;
            r_saved_value <= '0;
            r_ld_pend     <= 1'b0;
            r_ld_fmt      <= '0;
            r_ld_dst      <= '0;
            r_ld_addr     <= '0;
            r_isp         <= '0;
        end else begin
            if (sp_we) r_isp <= pwdata;
            if (i_valid && !o_stall) begin
                r_iv    <= 1'b1;
                r_mode  <= i_mode;
                r_instr <= i_instruction;
                r_ldata <= i_load_data;
                r_fault <= i_load_fault;
            end else if (adv) begin
                r_iv <= 1'b0;
            end
            if (adv) begin
                r_ov  <= 1'b1;
                r_res <= res;
                r_pc  <= upd.pc;
                if (upd.trap) begin
                    r_saved_pc    <= r_pc;
                    r_saved_cause <= res.trap_cause;
                    r_saved_value <= res.trap_value;
                end
                if (upd.ld_set) begin
                    r_ld_pend <= 1'b1;
                    r_ld_fmt  <= upd.ld_fmt;
                    r_ld_dst  <= upd.ld_dst;
                    r_ld_addr <= upd.ld_addr;
                end else if (upd.ld_clr) begin
                    r_ld_pend <= 1'b0;
                end
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // saved cause/value are architectural only; not visible on the ports
    logic unused_ok;
    assign unused_ok = ^{r_saved_cause, r_saved_value};

    assign o_valid       = r_ov;
    assign o_kind        = r_res.kind;
    assign o_next_pc     = r_res.next_pc;
    assign o_mem_address = r_res.mem_address;
    assign o_mem_size    = r_res.mem_size;
    assign o_store_data  = r_res.store_data;
    assign o_trap_cause  = r_res.trap_cause;
    assign o_trap_value  = r_res.trap_value;

endmodule
